@@ hdl/ws2812_four_lane_nibble_encoder_core_macros.svh @@
// Assertion macros shared by the four-lane nibble encoder RTL.
`ifndef WS2812_FOUR_LANE_NIBBLE_ENCODER_CORE_MACROS_SVH
`define WS2812_FOUR_LANE_NIBBLE_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define W4NE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("w4ne: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define W4NE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("w4ne: next-cycle check failed");

`endif

@@ hdl/w4ne_pkg.sv @@
// Types, constants and helpers for the four-lane nibble encoder.
`timescale 1ns / 1ps
`default_nettype none
package w4ne_pkg;

  localparam int RAIL_W     = 8;
  localparam int LANES      = 4;
  localparam int NIB_CNT    = 8;
  localparam int WORD_W     = 32;
  localparam int GAP_W      = 7;
  localparam int IDX_W      = 6;

  localparam logic [GAP_W-1:0] GAP_RESET     = 7'd50;
  localparam logic [GAP_W-1:0] GAP_MAX       = 7'd64;
  localparam logic [IDX_W-1:0] DATA_LAST_IDX = 6'd7;
  localparam logic [IDX_W-1:0] GAP_LAST_MAX  = 6'd63;

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;

  // Request kinds on the input channel
  typedef enum logic {
    REQ_DATA = 1'b0,
    REQ_GAP  = 1'b1
  } req_kind_t;

  // Classified command handed from the front end to the word generator
  typedef struct packed {
    logic                            is_gap;
    logic [IDX_W-1:0]                last_idx;
    logic [NIB_CNT-1:0][LANES-1:0]   nib;
  } cmd_t;

  // Bus word for one lane nibble: FF, nn, n0, 00
  function automatic logic [WORD_W-1:0] lane_word(input logic [LANES-1:0] n);
    lane_word = {BYTE_ONES, n, n, n, 4'h0, BYTE_ZEROS};
  endfunction

endpackage
`default_nettype wire

@@ hdl/w4ne_in_if.sv @@
// Input channel: request kind and one colour byte per rail.
`timescale 1ns / 1ps
`default_nettype none
interface w4ne_in_if import w4ne_pkg::*;;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [RAIL_W-1:0] rail0_byte;
  logic [RAIL_W-1:0] rail1_byte;
  logic [RAIL_W-1:0] rail2_byte;
  logic [RAIL_W-1:0] rail3_byte;

  modport source (output valid, req_type, rail0_byte, rail1_byte, rail2_byte, rail3_byte,
                  input ready);
  modport sink   (input valid, req_type, rail0_byte, rail1_byte, rail2_byte, rail3_byte,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/w4ne_out_if.sv @@
// Result channel: one 32-bit bus word and its last flag.
`timescale 1ns / 1ps
`default_nettype none
interface w4ne_out_if import w4ne_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] bus_word;
  logic              last_word;

  modport source (output valid, bus_word, last_word, input ready);
  modport sink   (input valid, bus_word, last_word, output ready);
endinterface
`default_nettype wire

@@ hdl/ws2812_four_lane_nibble_encoder_core.sv @@
// WS2812 four-lane encoder: data items become eight quad-SPI words, gap items zero words.
//
// Usage:
//   in_ch  : valid/ready channel; req_type 0 carries one colour byte per rail, req_type 1
//            asks for a reset gap (rail bytes ignored).
//   out_ch : valid/ready channel of 32-bit bus words, first byte in bits 31..24;
//            last_word marks the final word of each input transaction.
//   cfg_we/cfg_wdata : gap length in words, clamped to 1..64, reset value 50.
// Items pass input stage, command queue, generator command and output registers.
// Throughput: one bus word per cycle, set by the word generator, while out_ch is ready
//   and commands wait; a data item is eight words, a gap item its word count.
// Input stage plus a QUEUE_DEPTH-entry command queue absorb items while the generator
//   works, so in_ch takes a new transaction every cycle until the queue fills.
// A stalled receiver holds the output register; the generator and then the queue
//   back up, and in_ch ready drops. No words are dropped or duplicated.
// Reset (synchronous, rst_n low) empties all stages and restores the gap length.
`timescale 1ns / 1ps
`default_nettype none
module ws2812_four_lane_nibble_encoder_core import w4ne_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [GAP_W-1:0] cfg_wdata,
  w4ne_in_if.sink               in_ch,
  w4ne_out_if.source            out_ch
);

  cmd_t f_cmd;
  logic f_valid, f_ready;
  cmd_t q_cmd;
  logic q_valid, q_take;

  w4ne_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .f_cmd     (f_cmd),
    .f_valid   (f_valid),
    .f_ready   (f_ready)
  );

  w4ne_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (f_cmd),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_cmd    (q_cmd),
    .pop_valid  (q_valid),
    .pop_take   (q_take)
  );

  w4ne_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_take  (q_take),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

@@ hdl/w4ne_front.sv @@
// Front end: gap register, input acceptance, bit transpose and gap length clamp.
`timescale 1ns / 1ps
`default_nettype none
module w4ne_front import w4ne_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [GAP_W-1:0] cfg_wdata,
  w4ne_in_if.sink               in_ch,
  output cmd_t                  f_cmd,
  output logic                  f_valid,
  input  wire logic             f_ready
);

  logic [GAP_W-1:0] gap_words_r, gap_words_nxt;
  logic             valid_r, valid_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             accept;
  logic [IDX_W-1:0] gap_last;

  // Configuration register
  always_comb begin
    gap_words_nxt = cfg_we ? cfg_wdata : gap_words_r;
  end

  // Stage register frees when empty or when the queue takes its transaction
  assign in_ch.ready = !valid_r || f_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Gap length: zero counts as one word, above the max saturates
  always_comb begin
    if (gap_words_r == '0) begin
      gap_last = '0;
    end else if (gap_words_r > GAP_MAX) begin
      gap_last = GAP_LAST_MAX;
    end else begin
      gap_last = IDX_W'(gap_words_r - GAP_W'(1));
    end
  end

  // Classify and transpose: nibble k holds bit (7-k) of rail0..rail3
  always_comb begin
    cmd_nxt   = cmd_r;
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt       = 1'b1;
      cmd_nxt.is_gap  = (req_kind_t'(in_ch.req_type) == REQ_GAP);
      cmd_nxt.last_idx = cmd_nxt.is_gap ? gap_last : DATA_LAST_IDX;
      for (int k = 0; k < NIB_CNT; k++) begin
        cmd_nxt.nib[k] = {in_ch.rail0_byte[NIB_CNT-1-k], in_ch.rail1_byte[NIB_CNT-1-k],
                          in_ch.rail2_byte[NIB_CNT-1-k], in_ch.rail3_byte[NIB_CNT-1-k]};
      end
    end else if (f_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_words_r <= GAP_RESET;
      valid_r     <= 1'b0;
    end else begin
      gap_words_r <= gap_words_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign f_cmd   = cmd_r;
  assign f_valid = valid_r;

endmodule
`default_nettype wire

@@ hdl/w4ne_queue.sv @@
// Command queue between the front end and the word generator.
`timescale 1ns / 1ps
`default_nettype none
`include "ws2812_four_lane_nibble_encoder_core_macros.svh"
module w4ne_queue import w4ne_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t push_cmd,
  input  wire logic push_valid,
  output logic      push_ready,
  output cmd_t      pop_cmd,
  output logic      pop_valid,
  input  wire logic pop_take
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_take && pop_valid;
  assign pop_cmd    = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `W4NE_ASSERT_NOW(a_q_count_bound, clk, rst_n, 1'b1, count_r <= CNT_FULL)
  `W4NE_ASSERT_NEXT(a_q_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)
  `W4NE_ASSERT_NEXT(a_q_count_down, clk, rst_n, pop && !push, count_r == $past(count_r) - 1'b1)

endmodule
`default_nettype wire

@@ hdl/w4ne_back.sv @@
// Word generator: walks one command a word per cycle into the output register while that register can load.
`timescale 1ns / 1ps
`default_nettype none
`include "ws2812_four_lane_nibble_encoder_core_macros.svh"
module w4ne_back import w4ne_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t q_cmd,
  input  wire logic q_valid,
  output logic      q_take,
  w4ne_out_if.source out_ch
);

  cmd_t              cmd_r, cmd_nxt;
  logic              cmd_valid_r, cmd_valid_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_last_r, out_last_nxt;
  logic              can_load, emit, cur_last;
  logic [WORD_W-1:0] cur_word;
  logic              data_cmd, out_no_mark;

  // Current word of the active command
  assign can_load = !out_valid_r || out_ch.ready;
  assign emit     = cmd_valid_r && can_load;
  assign cur_last = (idx_r == cmd_r.last_idx);
  assign cur_word = cmd_r.is_gap ? '0 : lane_word(cmd_r.nib[idx_r[2:0]]);

  // Fetch next command when idle or while the last word of the current one goes out
  assign q_take = q_valid && (!cmd_valid_r || (emit && cur_last));

  always_comb begin
    cmd_nxt       = cmd_r;
    cmd_valid_nxt = cmd_valid_r;
    idx_nxt       = idx_r;
    if (q_take) begin
      cmd_nxt       = q_cmd;
      cmd_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (emit) begin
      if (cur_last) begin
        cmd_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = cur_word;
      out_last_nxt  = cur_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.bus_word  = out_word_r;
  assign out_ch.last_word = out_last_r;

  // Terms for the checks below
  assign data_cmd    = cmd_valid_r && !cmd_r.is_gap;
  assign out_no_mark = out_valid_r && (out_word_r[31:24] != BYTE_ONES);

  `W4NE_ASSERT_NOW(a_b_idx_bound, clk, rst_n, cmd_valid_r, idx_r <= cmd_r.last_idx)
  `W4NE_ASSERT_NOW(a_b_data_len, clk, rst_n, data_cmd, cmd_r.last_idx == DATA_LAST_IDX)
  `W4NE_ASSERT_NOW(a_b_word_form, clk, rst_n, out_no_mark, out_word_r == '0)

endmodule
`default_nettype wire
